@@ rtl/core/note_bend_tracker_unit_assert.svh @@
// Assertion macros used by the note bend tracker top level.
`ifndef NOTE_BEND_TRACKER_UNIT_ASSERT_SVH
`define NOTE_BEND_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define NBT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define NBT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/nbt_pkg.sv @@
// Package with the beat types, table control type and constants of the note bend tracker.
package nbt_pkg;

    localparam int PITCH_W = 15;
    localparam int VEL_W   = 8;
    localparam int BEND_W  = 8;
    localparam int OFS_W   = 10;

    localparam logic [PITCH_W-1:0] PITCH_MAX = 15'h7fff;

    // Reciprocal of 127 scaled by 2^21; exact for (x + 1) * BEND_RECIP >> 21 below 2^15.
    localparam logic [14:0] BEND_RECIP = 15'd16513;
    localparam int          RECIP_SH   = 21;
    // Half-up rounding term plus one, folded into the low byte of the numerator.
    localparam logic [7:0]  BEND_RND1  = 8'd64;

    // One input beat.
    typedef struct packed {
        logic               note_on;
        logic [PITCH_W-1:0] pitch;
        logic [VEL_W-1:0]   velocity;
        logic [BEND_W-1:0]  bend;
    } t_in;

    // One result beat.
    typedef struct packed {
        logic [PITCH_W-1:0] out_pitch;
        logic [VEL_W-1:0]   out_velocity;
        logic               out_on;
        logic               tracked;
    } t_out;

    // Table access request from the controller.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_used;
    } t_tbl_ctrl;

endpackage

@@ rtl/core/nbt_bend.sv @@
// Bend byte to pitch offset conversion and saturating bent pitch adder.
module nbt_bend (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic [nbt_pkg::BEND_W-1:0]    i_bend,
    input  logic [nbt_pkg::PITCH_W-1:0]   i_pitch,
    output logic [nbt_pkg::PITCH_W-1:0]   o_bent
);

    logic signed [nbt_pkg::OFS_W-1:0] r_offset;
    logic signed [nbt_pkg::OFS_W-1:0] n_offset;
    logic [14:0]                      w_num;
    logic [29:0]                      w_prod;
    logic [8:0]                       w_quot;
    logic signed [16:0]               w_sum;

    // Upward bend: ((d * 256 + 63) / 127) as a reciprocal multiply of d * 256 + 64.
    assign w_num  = {i_bend[6:0], nbt_pkg::BEND_RND1};
    assign w_prod = 30'(w_num) * 30'(nbt_pkg::BEND_RECIP);
    assign w_quot = w_prod[29:nbt_pkg::RECIP_SH];

    // Downward bend is exact: two units per step below the center code.
    always_comb begin
        if (i_bend[7]) begin
            n_offset = $signed({1'b0, w_quot});
        end else begin
            n_offset = $signed({1'b0, i_bend, 1'b0}) - 10'sd256;
        end
    end

    // The offset is captured with the accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_offset <= n_offset;
        end
    end

    // Apply the offset and clamp to the pitch range.
    assign w_sum = $signed({2'b00, i_pitch}) + 17'(r_offset);

    always_comb begin
        if (w_sum < 17'sd0) begin
            o_bent = '0;
        end else if (w_sum > $signed({2'b00, nbt_pkg::PITCH_MAX})) begin
            o_bent = nbt_pkg::PITCH_MAX;
        end else begin
            o_bent = w_sum[nbt_pkg::PITCH_W-1:0];
        end
    end

endmodule

@@ rtl/core/nbt_table.sv @@
// Note table: written and bent pitch memories plus the per-entry used flags.
module nbt_table #(
    parameter int ENTRIES = 16,
    parameter int IW      = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nbt_pkg::t_tbl_ctrl            i_ctrl,
    input  logic [IW-1:0]                 i_addr,
    input  logic [nbt_pkg::PITCH_W-1:0]   i_wr_written,
    input  logic [nbt_pkg::PITCH_W-1:0]   i_wr_bent,
    output logic [nbt_pkg::PITCH_W-1:0]   o_rd_written,
    output logic [nbt_pkg::PITCH_W-1:0]   o_rd_bent,
    output logic [ENTRIES-1:0]            o_used
);

    logic [nbt_pkg::PITCH_W-1:0] r_written_mem [ENTRIES];
    logic [nbt_pkg::PITCH_W-1:0] r_bent_mem    [ENTRIES];
    logic [ENTRIES-1:0]          r_used;

    // Single-port memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_written_mem[i_addr] <= i_wr_written;
            r_bent_mem[i_addr]    <= i_wr_bent;
        end
        if (i_ctrl.rd_en) begin
            o_rd_written <= r_written_mem[i_addr];
            o_rd_bent    <= r_bent_mem[i_addr];
        end
    end

    // Used flags: set by a stored note start, cleared by a tracked release.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_ctrl.wr_en) begin
            r_used[i_addr] <= 1'b1;
        end else if (i_ctrl.clr_used) begin
            r_used[i_addr] <= 1'b0;
        end
    end

    assign o_used = r_used;

endmodule

@@ rtl/core/note_bend_tracker_unit.sv @@
// Top level of the note bend tracker: event controller, table and bend unit.
//
// Usage: an event beat is taken when start is high and busy is low. Each event
// gives exactly one result beat, shown on o_result for a single cycle with
// o_strobe high; the receiver cannot stall it. For a note start or an
// untracked release, the time from acceptance to the result strobe is set by
// the search, which reads one written-pitch entry per cycle from the
// single-port table memory; a tracked release adds one read of the stored
// bent pitch. busy drops in the cycle the result strobe rises, so the
// next event may be given while the result is on the ports. The table needs no
// clearing after reset: only the used flags are reset.
`include "note_bend_tracker_unit_assert.svh"

module note_bend_tracker_unit #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  nbt_pkg::t_in  i_item,
    output logic          o_strobe,
    output nbt_pkg::t_out o_result
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] CNT_END = CW'(TABLE_ENTRIES);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_SCAN    = 2'd1;
    localparam logic [1:0] S_RESOLVE = 2'd2;
    localparam logic [1:0] S_READ    = 2'd3;

    logic [1:0]                  r_state;
    logic [1:0]                  n_state;
    nbt_pkg::t_in                r_item;
    logic [CW-1:0]               r_cnt;
    logic                        r_cmp_vld;
    logic [IW-1:0]               r_cmp_idx;
    logic                        r_found;
    logic [IW-1:0]               r_match;
    logic                        r_free_ok;
    logic [IW-1:0]               r_free;
    logic                        r_out_vld;
    logic                        n_out_vld;
    nbt_pkg::t_out               r_out;
    nbt_pkg::t_out               n_out;

    logic                        w_accept;
    logic                        w_hit;
    logic                        w_empty;
    nbt_pkg::t_tbl_ctrl          w_ctrl;
    logic [IW-1:0]               w_addr;
    logic [nbt_pkg::PITCH_W-1:0] w_rd_written;
    logic [nbt_pkg::PITCH_W-1:0] w_rd_bent;
    logic [TABLE_ENTRIES-1:0]    w_used;
    logic [nbt_pkg::PITCH_W-1:0] w_bent;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    // Bend offset is captured with the beat; the bent pitch follows the held pitch.
    nbt_bend u_bend (
        .i_clk   (i_clk),
        .i_load  (w_accept),
        .i_bend  (i_item.bend),
        .i_pitch (r_item.pitch),
        .o_bent  (w_bent)
    );

    nbt_table #(
        .ENTRIES (TABLE_ENTRIES),
        .IW      (IW)
    ) u_table (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_addr       (w_addr),
        .i_wr_written (r_item.pitch),
        .i_wr_bent    (w_bent),
        .o_rd_written (w_rd_written),
        .o_rd_bent    (w_rd_bent),
        .o_used       (w_used)
    );

    // Compare stage of the search, in the cycle after its read address.
    assign w_hit   = r_cmp_vld && w_used[r_cmp_idx] && (w_rd_written == r_item.pitch);
    assign w_empty = r_cmp_vld && !w_used[r_cmp_idx];

    // Controller: next state, table requests and the result beat.
    always_comb begin
        n_state   = r_state;
        w_ctrl    = '0;
        w_addr    = r_cnt[IW-1:0];
        n_out_vld = 1'b0;
        n_out     = r_out;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_cnt != CNT_END) begin
                    w_ctrl.rd_en = 1'b1;
                end else begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                if (r_item.note_on) begin
                    // Reuse a held entry, else take the first free one.
                    w_addr              = r_found ? r_match : r_free;
                    w_ctrl.wr_en        = r_found || r_free_ok;
                    n_out.out_pitch     = w_bent;
                    n_out.out_velocity  = r_item.velocity;
                    n_out.out_on        = 1'b1;
                    n_out.tracked       = r_found || r_free_ok;
                    n_out_vld           = 1'b1;
                    n_state             = S_IDLE;
                end else if (r_found) begin
                    w_addr       = r_match;
                    w_ctrl.rd_en = 1'b1;
                    n_state      = S_READ;
                end else begin
                    n_out.out_pitch    = w_bent;
                    n_out.out_velocity = '0;
                    n_out.out_on       = 1'b0;
                    n_out.tracked      = 1'b0;
                    n_out_vld          = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_READ: begin
                // Tracked release ends at the stored pitch and frees the entry.
                w_addr             = r_match;
                w_ctrl.clr_used    = 1'b1;
                n_out.out_pitch    = w_rd_bent;
                n_out.out_velocity = '0;
                n_out.out_on       = 1'b0;
                n_out.tracked      = 1'b1;
                n_out_vld          = 1'b1;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_free_ok <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_cmp_vld <= (r_state == S_SCAN) && (r_cnt != CNT_END);
            if (w_accept) begin
                r_cnt     <= '0;
                r_found   <= 1'b0;
                r_free_ok <= 1'b0;
            end else begin
                if ((r_state == S_SCAN) && (r_cnt != CNT_END)) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (w_hit && !r_found) begin
                    r_found <= 1'b1;
                end
                if (w_empty && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                end
            end
        end
    end

    // Payload registers: held beat, search indexes and the result.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
        r_cmp_idx <= r_cnt[IW-1:0];
        if (w_hit && !r_found) begin
            r_match <= r_cmp_idx;
        end
        if (w_empty && !r_free_ok) begin
            r_free <= r_cmp_idx;
        end
        r_out <= n_out;
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    `NBT_ASSERT_NEXT(a_accept_busy, w_accept, busy, "accepted beat did not raise busy")
    `NBT_ASSERT_NEXT(a_strobe_single, o_strobe, !o_strobe, "result strobe lasted more than one cycle")
    `NBT_ASSERT_NOW(a_release_vel, o_strobe && !o_result.out_on, o_result.out_velocity == '0, "release result with nonzero velocity")
    `NBT_ASSERT_NOW(a_match_used, (r_state == S_RESOLVE) && r_found, w_used[r_match], "matched entry is not in use")
    `NBT_ASSERT_NEXT(a_release_frees, r_state == S_READ, !w_used[$past(r_match)], "tracked release did not free its entry")

endmodule
